[hdl/sshet_pkg.sv]
// sshet_pkg: shared constants and control types for the speed smoothing tracker
// no dependencies

package sshet_pkg;

  localparam int SPEED_W      = 15;
  localparam int SAMPLE_W     = 16;
  localparam int ACC_W        = 16;
  localparam int HCNT_W       = 16;
  localparam int THR_W        = 15;
  localparam int AGGR_W       = 16;
  localparam int SAMPLE_CNT_W = 20;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;

  localparam int DEF_WINDOW      = 3;
  localparam int DEF_COUNT_WIDTH = 20;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(160);
  localparam logic [AGGR_W-1:0] AGGR_RESET = AGGR_W'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_HARSH_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGGRESSIVE_MIN  = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic capture;
    logic clear;
    logic smooth_start;
    logic update;
    logic mean_start;
    logic mean_load;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_clear;
    logic is_neg;
  } status_t;

endpackage

[hdl/sshet_div.sv]
// sshet_div: serial restoring divider, one quotient bit per cycle
// depends on sshet_pkg

module sshet_div #(
  parameter int DW = 35,
  parameter int VW = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DW-1:0]               dividend_i,
  input  logic [VW-1:0]               divisor_i,
  input  logic [$clog2(DW+1)-1:0]     nbits_i,
  output logic                        done_o,
  output logic [sshet_pkg::SPEED_W-1:0] quotient_o
);

  localparam int NW = $clog2(DW+1);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;
  logic [NW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          ge;

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= nbits_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - NW'(1);
        if (cnt_q == NW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[sshet_pkg::SPEED_W-1:0];

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider not busy after start");
`endif

endmodule

[hdl/sshet_dp.sv]
// sshet_dp: trip state, moving-average window, config registers and result registers
// depends on sshet_pkg and sshet_div

module sshet_dp #(
  parameter int WINDOW      = sshet_pkg::DEF_WINDOW,
  parameter int COUNT_WIDTH = sshet_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sshet_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sshet_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  operation_i,
  input  logic signed [sshet_pkg::SAMPLE_W-1:0] speed_sample_i,
  input  sshet_pkg::cmd_t                       cmd_i,
  output sshet_pkg::status_t                    status_o,
  output logic                                  sample_kept_o,
  output logic [sshet_pkg::SPEED_W-1:0]         smoothed_speed_o,
  output logic signed [sshet_pkg::ACC_W-1:0]    acceleration_o,
  output logic                                  acceleration_valid_o,
  output logic                                  harsh_event_o,
  output logic [sshet_pkg::HCNT_W-1:0]          harsh_count_o,
  output logic                                  aggressive_o,
  output logic [sshet_pkg::SPEED_W-1:0]         average_speed_o,
  output logic [sshet_pkg::SPEED_W-1:0]         max_speed_o,
  output logic [sshet_pkg::SAMPLE_CNT_W-1:0]    sample_count_o
);

  localparam int SW  = sshet_pkg::SPEED_W;
  localparam int HD  = (WINDOW > 1) ? WINDOW - 1 : 1;
  localparam int FW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SMW = SW + $clog2(WINDOW);
  localparam int DW  = SW + COUNT_WIDTH;
  localparam int NW  = $clog2(DW + 1);

  logic [sshet_pkg::THR_W-1:0]  thr_q;
  logic [sshet_pkg::AGGR_W-1:0] aggr_q;

  logic                          op_q;
  logic [sshet_pkg::SAMPLE_W-1:0] sample_q;

  logic [SW-1:0]          hist_q [HD];
  logic [FW-1:0]          fill_q;
  logic [SW-1:0]          prev_q;
  logic                   have_prev_q;
  logic [sshet_pkg::HCNT_W-1:0] hcnt_q;
  logic [DW-1:0]          sum_q;
  logic [COUNT_WIDTH-1:0] kept_cnt_q;
  logic [SW-1:0]          max_q;
  logic [SW-1:0]          avg_q;

  logic                   r_kept_q;
  logic [SW-1:0]          r_smooth_q;
  logic [sshet_pkg::ACC_W-1:0] r_acc_q;
  logic                   r_accv_q;
  logic                   r_harsh_q;

  logic [SMW-1:0]         wsum;
  logic                   div_start;
  logic [DW-1:0]          div_dividend;
  logic [COUNT_WIDTH-1:0] div_divisor;
  logic [NW-1:0]          div_nbits;
  logic                   div_done;
  logic [SW-1:0]          quo;
  logic [sshet_pkg::ACC_W-1:0] acc;
  logic [sshet_pkg::ACC_W-1:0] mag;
  logic                   harsh;

  // window sum over the current sample and the valid history
  always_comb begin
    wsum = SMW'(sample_q[SW-1:0]);
    for (int i = 0; i < HD; i++) begin
      if (WINDOW > 1 && fill_q > FW'(i)) begin
        wsum = wsum + SMW'(hist_q[i]);
      end
    end
  end

  always_comb begin
    div_start = cmd_i.smooth_start | cmd_i.mean_start;
    if (cmd_i.smooth_start) begin
      div_dividend = {wsum, {(DW - SMW){1'b0}}};
      div_divisor  = COUNT_WIDTH'(fill_q) + COUNT_WIDTH'(1);
      div_nbits    = NW'(SMW);
    end else begin
      div_dividend = sum_q;
      div_divisor  = kept_cnt_q;
      div_nbits    = NW'(DW);
    end
  end

  sshet_div #(
    .DW(DW),
    .VW(COUNT_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .nbits_i   (div_nbits),
    .done_o    (div_done),
    .quotient_o(quo)
  );

  assign acc   = {1'b0, quo} - {1'b0, prev_q};
  assign mag   = acc[sshet_pkg::ACC_W-1] ? -acc : acc;
  assign harsh = have_prev_q && (mag > {1'b0, thr_q});

  assign status_o.div_done = div_done;
  assign status_o.is_clear = (op_q == sshet_pkg::OP_CLEAR);
  assign status_o.is_neg   = sample_q[sshet_pkg::SAMPLE_W-1];

  // config registers and trip state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= sshet_pkg::THR_RESET;
      aggr_q      <= sshet_pkg::AGGR_RESET;
      fill_q      <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      hcnt_q      <= '0;
      sum_q       <= '0;
      kept_cnt_q  <= '0;
      max_q       <= '0;
      avg_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sshet_pkg::CFG_HARSH_THRESHOLD: thr_q  <= cfg_data_i[sshet_pkg::THR_W-1:0];
          sshet_pkg::CFG_AGGRESSIVE_MIN:  aggr_q <= cfg_data_i[sshet_pkg::AGGR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clear) begin
        fill_q      <= '0;
        prev_q      <= '0;
        have_prev_q <= 1'b0;
        hcnt_q      <= '0;
        sum_q       <= '0;
        kept_cnt_q  <= '0;
        max_q       <= '0;
        avg_q       <= '0;
      end
      if (cmd_i.update) begin
        if (fill_q < FW'(WINDOW - 1)) begin
          fill_q <= fill_q + FW'(1);
        end
        prev_q      <= quo;
        have_prev_q <= 1'b1;
        if (harsh && hcnt_q != '1) begin
          hcnt_q <= hcnt_q + sshet_pkg::HCNT_W'(1);
        end
        if (quo > max_q) begin
          max_q <= quo;
        end
        if (kept_cnt_q != '1) begin
          kept_cnt_q <= kept_cnt_q + COUNT_WIDTH'(1);
          sum_q      <= sum_q + DW'(quo);
        end
      end
      if (cmd_i.mean_load) begin
        avg_q <= quo;
      end
    end
  end

  // beat capture, history shift, per-item results and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= operation_i;
      sample_q   <= speed_sample_i;
      r_kept_q   <= 1'b0;
      r_smooth_q <= '0;
      r_acc_q    <= '0;
      r_accv_q   <= 1'b0;
      r_harsh_q  <= 1'b0;
    end
    if (cmd_i.update) begin
      hist_q[0] <= sample_q[SW-1:0];
      for (int i = 1; i < HD; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
      r_kept_q   <= 1'b1;
      r_smooth_q <= quo;
      r_acc_q    <= have_prev_q ? acc : '0;
      r_accv_q   <= have_prev_q;
      r_harsh_q  <= harsh;
    end
    if (cmd_i.load_out) begin
      sample_kept_o        <= r_kept_q;
      smoothed_speed_o     <= r_smooth_q;
      acceleration_o       <= r_acc_q;
      acceleration_valid_o <= r_accv_q;
      harsh_event_o        <= r_harsh_q;
      harsh_count_o        <= hcnt_q;
      aggressive_o         <= hcnt_q >= aggr_q;
      average_speed_o      <= avg_q;
      max_speed_o          <= max_q;
      sample_count_o       <= sshet_pkg::SAMPLE_CNT_W'(kept_cnt_q);
    end
  end

`ifndef SYNTH
  a_max_covers_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_q >= prev_q)
    else $error("maximum below last smoothed speed");
  a_update_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> have_prev_q)
    else $error("previous smoothed speed not marked after update");
`endif

endmodule

[hdl/sshet_ctrl.sv]
// sshet_ctrl: sequencing state machine and channel handshake for one beat at a time
// depends on sshet_pkg

module sshet_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  sshet_pkg::status_t status_i,
  output sshet_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SMOOTH,
    S_MEAN_GO,
    S_MEAN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !stall_q) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.is_clear) begin
          cmd_o.clear = 1'b1;
          state_d     = S_FINISH;
        end else if (status_i.is_neg) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.smooth_start = 1'b1;
          state_d            = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        if (status_i.div_done) begin
          cmd_o.update = 1'b1;
          state_d      = S_MEAN_GO;
        end
      end
      S_MEAN_GO: begin
        cmd_o.mean_start = 1'b1;
        state_d          = S_MEAN;
      end
      S_MEAN: begin
        if (status_i.div_done) begin
          cmd_o.mean_load = 1'b1;
          state_d         = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stall_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stall_q     <= (state_d != S_IDLE);
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = stall_q;
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_done_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_SMOOTH || state_q == S_MEAN))
    else $error("divider finished outside a divide state");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("result loaded without valid");
  a_smooth_to_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SMOOTH && status_i.div_done) |=> state_q == S_MEAN_GO)
    else $error("mean division not started after smoothing");
`endif

endmodule

[hdl/speed_smoothing_harsh_event_tracker_top.sv]
// speed_smoothing_harsh_event_tracker_top: top level, controller plus datapath
// depends on sshet_pkg, sshet_ctrl, sshet_dp (which holds sshet_div)
//
//   channel | handshake               | payload
//   in      | in_valid_i / in_stall_o | operation_i, speed_sample_i
//   out     | out_valid_o/out_stall_i | sample_kept_o .. sample_count_o
//   cfg     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// one beat at a time; from accept to next accept a clear or negative sample goes from decode
// straight to the finish state, while a kept sample waits on the shared serial divider
// that forms first the window average, then the trip mean
// reset clears all trip state asynchronously, no clearing pass
// a finished result sits in the output register; the next beat is accepted meanwhile,
// and the block waits at its end while an earlier result is still stalled

module speed_smoothing_harsh_event_tracker_top #(
  parameter int WINDOW      = sshet_pkg::DEF_WINDOW,
  parameter int COUNT_WIDTH = sshet_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sshet_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sshet_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  operation_i,
  input  logic signed [sshet_pkg::SAMPLE_W-1:0] speed_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  sample_kept_o,
  output logic [sshet_pkg::SPEED_W-1:0]         smoothed_speed_o,
  output logic signed [sshet_pkg::ACC_W-1:0]    acceleration_o,
  output logic                                  acceleration_valid_o,
  output logic                                  harsh_event_o,
  output logic [sshet_pkg::HCNT_W-1:0]          harsh_count_o,
  output logic                                  aggressive_o,
  output logic [sshet_pkg::SPEED_W-1:0]         average_speed_o,
  output logic [sshet_pkg::SPEED_W-1:0]         max_speed_o,
  output logic [sshet_pkg::SAMPLE_CNT_W-1:0]    sample_count_o
);

  sshet_pkg::cmd_t    cmd;
  sshet_pkg::status_t status;

  sshet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sshet_dp #(
    .WINDOW     (WINDOW),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .operation_i         (operation_i),
    .speed_sample_i      (speed_sample_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .sample_kept_o       (sample_kept_o),
    .smoothed_speed_o    (smoothed_speed_o),
    .acceleration_o      (acceleration_o),
    .acceleration_valid_o(acceleration_valid_o),
    .harsh_event_o       (harsh_event_o),
    .harsh_count_o       (harsh_count_o),
    .aggressive_o        (aggressive_o),
    .average_speed_o     (average_speed_o),
    .max_speed_o         (max_speed_o),
    .sample_count_o      (sample_count_o)
  );

endmodule

[verif/speed_smoothing_harsh_event_tracker_top_tb.sv]
// speed_smoothing_harsh_event_tracker_top_tb: self-checking bench for the speed tracker,
// predicts every result beat from the accepted input beats and compares it field by field
// depends on sshet_pkg and speed_smoothing_harsh_event_tracker_top

module speed_smoothing_harsh_event_tracker_top_tb;

  localparam int              HIST_DEPTH      = (sshet_pkg::DEF_WINDOW > 1) ?
                                                sshet_pkg::DEF_WINDOW - 1 : 1;
  localparam longint unsigned KEPT_MAX        = (64'd1 << sshet_pkg::DEF_COUNT_WIDTH) - 1;
  localparam int              PHASES          = 6;
  localparam int              ITEMS_PER_PHASE = 100;
  localparam int              SETTLE_CYCLES   = 8;
  localparam int              TAIL_CYCLES     = 120;
  localparam int              HOLD_OFF_CYCLES = 400;
  localparam int              WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    logic                               sample_kept;
    logic [sshet_pkg::SPEED_W-1:0]      smoothed_speed;
    logic [sshet_pkg::ACC_W-1:0]        acceleration;
    logic                               acceleration_valid;
    logic                               harsh_event;
    logic [sshet_pkg::HCNT_W-1:0]       harsh_count;
    logic                               aggressive;
    logic [sshet_pkg::SPEED_W-1:0]      average_speed;
    logic [sshet_pkg::SPEED_W-1:0]      max_speed;
    logic [sshet_pkg::SAMPLE_CNT_W-1:0] sample_count;
  } trip_report_t;

  class trip_scoreboard;
    logic [sshet_pkg::THR_W-1:0]   harsh_threshold;
    logic [sshet_pkg::AGGR_W-1:0]  min_events;
    logic [sshet_pkg::SPEED_W-1:0] history [HIST_DEPTH];
    int unsigned                   fill;
    logic [sshet_pkg::SPEED_W-1:0] prev_smooth;
    bit                            have_prev;
    logic [sshet_pkg::HCNT_W-1:0]  harsh_total;
    longint unsigned               speed_sum;
    longint unsigned               kept;
    logic [sshet_pkg::SPEED_W-1:0] peak_smooth;
    trip_report_t                  expected_reports[$];
    int                            errors;
    int                            kept_beats;
    int                            dropped_beats;
    int                            clear_beats;
    int                            harsh_beats;

    function new();
      harsh_threshold = sshet_pkg::THR_RESET;
      min_events      = sshet_pkg::AGGR_RESET;
      clear_trip();
    endfunction

    function void clear_trip();
      foreach (history[i]) history[i] = '0;
      fill        = 0;
      prev_smooth = '0;
      have_prev   = 1'b0;
      harsh_total = '0;
      speed_sum   = 0;
      kept        = 0;
      peak_smooth = '0;
    endfunction

    function void set_reg(logic [sshet_pkg::CFG_IDX_W-1:0] idx,
                          logic [sshet_pkg::CFG_DATA_W-1:0] data);
      if (idx == sshet_pkg::CFG_HARSH_THRESHOLD) begin
        harsh_threshold = data[sshet_pkg::THR_W-1:0];
      end else if (idx == sshet_pkg::CFG_AGGRESSIVE_MIN) begin
        min_events = data[sshet_pkg::AGGR_W-1:0];
      end
    endfunction

    function void predict_trip_report(logic op,
                                      logic signed [sshet_pkg::SAMPLE_W-1:0] raw);
      trip_report_t rep;
      int unsigned  sum;
      int unsigned  smooth;
      int unsigned  mag;
      int           acc;
      rep = '0;
      if (op == sshet_pkg::OP_CLEAR) begin
        clear_trip();
        clear_beats++;
      end else if (raw < 0) begin
        dropped_beats++;
      end else begin
        sum = raw[sshet_pkg::SPEED_W-1:0];
        for (int i = 0; i < fill; i++) sum += history[i];
        smooth = sum / (fill + 1);
        // newest sample sits at the front of the history
        for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
        if (sshet_pkg::DEF_WINDOW > 1) begin
          history[0] = raw[sshet_pkg::SPEED_W-1:0];
          if (fill < sshet_pkg::DEF_WINDOW - 1) fill++;
        end
        rep.sample_kept    = 1'b1;
        rep.smoothed_speed = smooth[sshet_pkg::SPEED_W-1:0];
        if (have_prev) begin
          acc = int'(smooth) - int'(prev_smooth);
          mag = (acc < 0) ? -acc : acc;
          rep.acceleration       = acc[sshet_pkg::ACC_W-1:0];
          rep.acceleration_valid = 1'b1;
          if (mag > harsh_threshold) begin
            rep.harsh_event = 1'b1;
            harsh_beats++;
            if (harsh_total != '1) harsh_total++;
          end
        end
        prev_smooth = smooth[sshet_pkg::SPEED_W-1:0];
        have_prev   = 1'b1;
        if (smooth > peak_smooth) peak_smooth = smooth[sshet_pkg::SPEED_W-1:0];
        if (kept < KEPT_MAX) begin
          kept++;
          speed_sum += smooth;
        end
        kept_beats++;
      end
      rep.harsh_count   = harsh_total;
      rep.aggressive    = (harsh_total >= min_events);
      rep.average_speed = (kept != 0) ? sshet_pkg::SPEED_W'(speed_sum / kept) : '0;
      rep.max_speed     = peak_smooth;
      rep.sample_count  = kept[sshet_pkg::SAMPLE_CNT_W-1:0];
      expected_reports = {expected_reports, rep};
    endfunction

    function void check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(trip_report_t got);
      trip_report_t want;
      if (expected_reports.size() == 0) begin
        $error("result beat with no input beat pending");
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      check_field("sample_kept", 32'(want.sample_kept), 32'(got.sample_kept));
      check_field("smoothed_speed", 32'(want.smoothed_speed), 32'(got.smoothed_speed));
      check_field("acceleration", 32'(signed'(want.acceleration)),
                  32'(signed'(got.acceleration)));
      check_field("acceleration_valid", 32'(want.acceleration_valid),
                  32'(got.acceleration_valid));
      check_field("harsh_event", 32'(want.harsh_event), 32'(got.harsh_event));
      check_field("harsh_count", 32'(want.harsh_count), 32'(got.harsh_count));
      check_field("aggressive", 32'(want.aggressive), 32'(got.aggressive));
      check_field("average_speed", 32'(want.average_speed), 32'(got.average_speed));
      check_field("max_speed", 32'(want.max_speed), 32'(got.max_speed));
      check_field("sample_count", 32'(want.sample_count), 32'(got.sample_count));
    endfunction
  endclass

  logic                                  clk_i = 1'b0;
  logic                                  rst_ni;
  logic                                  cfg_we_i;
  logic [sshet_pkg::CFG_IDX_W-1:0]       cfg_index_i;
  logic [sshet_pkg::CFG_DATA_W-1:0]      cfg_data_i;
  logic                                  in_valid_i;
  logic                                  in_stall_o;
  logic                                  operation_i;
  logic signed [sshet_pkg::SAMPLE_W-1:0] speed_sample_i;
  logic                                  out_valid_o;
  logic                                  out_stall_i;
  logic                                  sample_kept_o;
  logic [sshet_pkg::SPEED_W-1:0]         smoothed_speed_o;
  logic signed [sshet_pkg::ACC_W-1:0]    acceleration_o;
  logic                                  acceleration_valid_o;
  logic                                  harsh_event_o;
  logic [sshet_pkg::HCNT_W-1:0]          harsh_count_o;
  logic                                  aggressive_o;
  logic [sshet_pkg::SPEED_W-1:0]         average_speed_o;
  logic [sshet_pkg::SPEED_W-1:0]         max_speed_o;
  logic [sshet_pkg::SAMPLE_CNT_W-1:0]    sample_count_o;

  trip_scoreboard sb;
  bit             idle_on;
  bit             hold_off_req;
  int             quiet_cycles;

  speed_smoothing_harsh_event_tracker_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .operation_i          (operation_i),
    .speed_sample_i       (speed_sample_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .sample_kept_o        (sample_kept_o),
    .smoothed_speed_o     (smoothed_speed_o),
    .acceleration_o       (acceleration_o),
    .acceleration_valid_o (acceleration_valid_o),
    .harsh_event_o        (harsh_event_o),
    .harsh_count_o        (harsh_count_o),
    .aggressive_o         (aggressive_o),
    .average_speed_o      (average_speed_o),
    .max_speed_o          (max_speed_o),
    .sample_count_o       (sample_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (!idle_on || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  task automatic send_item(input logic op, input logic signed [sshet_pkg::SAMPLE_W-1:0] raw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    speed_sample_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    sb.predict_trip_report(op, raw);
  endtask

  task automatic drain(input int settle);
    in_valid_i <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [sshet_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sshet_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // result beats and watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({sample_kept_o, smoothed_speed_o, acceleration_o, acceleration_valid_o,
                       harsh_event_o, harsh_count_o, aggressive_o, average_speed_o,
                       max_speed_o, sample_count_o});
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(0, 3) == 0);
        repeat (1 + pick_gap()) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [sshet_pkg::CFG_DATA_W-1:0] thr_val;
    logic [sshet_pkg::CFG_DATA_W-1:0] min_val;
    int                               cruise;
    int                               step;
    int                               pick;
    int                               settings;
    sb             = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = sshet_pkg::CFG_HARSH_THRESHOLD;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    operation_i    = sshet_pkg::OP_SAMPLE;
    speed_sample_i = '0;
    out_stall_i    = 1'b0;
    quiet_cycles   = 0;
    idle_on        = 1'b1;
    hold_off_req   = 1'b0;
    settings       = 1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // directed, reset register values
    send_item(sshet_pkg::OP_SAMPLE, -16'sd1);
    send_item(sshet_pkg::OP_SAMPLE, 16'sd0);
    repeat (3) send_item(sshet_pkg::OP_SAMPLE, 16'sh7fff);
    send_item(sshet_pkg::OP_SAMPLE, 16'sh8000);
    send_item(sshet_pkg::OP_SAMPLE, -16'sd1);
    repeat (4) send_item(sshet_pkg::OP_SAMPLE, 16'sd0);
    send_item(sshet_pkg::OP_CLEAR, 16'sh7fff);
    // acceleration right at the threshold, then one above
    send_item(sshet_pkg::OP_SAMPLE, 16'sd300);
    send_item(sshet_pkg::OP_SAMPLE, 16'sd620);
    send_item(sshet_pkg::OP_SAMPLE, 16'sd943);
    send_item(sshet_pkg::OP_CLEAR, -16'sd1);
    send_item(sshet_pkg::OP_SAMPLE, 16'sd5);
    drain(SETTLE_CYCLES);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          thr_val = '0;
          min_val = '0;
        end
        1: begin
          thr_val = '1;
          min_val = '1;
        end
        2: begin
          thr_val = sshet_pkg::CFG_DATA_W'(sshet_pkg::THR_RESET);
          min_val = sshet_pkg::CFG_DATA_W'(sshet_pkg::AGGR_RESET);
        end
        default: begin
          thr_val = sshet_pkg::CFG_DATA_W'($urandom_range(0, 2000) |
                                           ($urandom_range(0, 1) << 15));
          min_val = sshet_pkg::CFG_DATA_W'($urandom_range(0, 12));
        end
      endcase
      write_reg(sshet_pkg::CFG_HARSH_THRESHOLD, thr_val);
      write_reg(sshet_pkg::CFG_AGGRESSIVE_MIN, min_val);
      settings++;
      idle_on = (phase != 2);
      if (phase == 3) hold_off_req = 1'b1;
      cruise = $urandom_range(0, 32767);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_item(sshet_pkg::OP_CLEAR, sshet_pkg::SAMPLE_W'($urandom));
        end else if (pick < 11) begin
          send_item(sshet_pkg::OP_SAMPLE, sshet_pkg::SAMPLE_W'($urandom_range(32768, 65535)));
        end else if (pick < 18) begin
          send_item(sshet_pkg::OP_SAMPLE, sshet_pkg::SAMPLE_W'($urandom));
        end else begin
          // drive-like speed profile, steps scaled around the threshold
          step   = $urandom_range(0, 4 * int'(sb.harsh_threshold) + 8);
          cruise = $urandom_range(0, 1) ? cruise + step : cruise - step;
          if (cruise < 0) cruise = 0;
          if (cruise > 32767) cruise = 32767;
          send_item(sshet_pkg::OP_SAMPLE, sshet_pkg::SAMPLE_W'(cruise));
        end
      end
      drain((phase == PHASES - 1) ? TAIL_CYCLES : SETTLE_CYCLES);
    end

    $display("run covered %0d kept samples, %0d negative samples and %0d trip clears",
             sb.kept_beats, sb.dropped_beats, sb.clear_beats);
    $display("%0d harsh events over %0d register settings, with a %0d-cycle output hold-off",
             sb.harsh_beats, settings, HOLD_OFF_CYCLES);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
